FILE: hw/rtl/sops_pkg.sv
// Scan obstacle push summary: shared types, register indexes and constants.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package sops_pkg;

   // Field and register widths
   localparam int unsigned COORD_W    = 16;
   localparam int unsigned DIST_W     = 15;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned Q88_W      = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Divider geometry: numerator is magnitude * 256000, divisor is x^2 + y^2
   localparam int unsigned SCALE_W = 18;
   localparam int unsigned NUM_W   = DIST_W + SCALE_W;
   localparam int unsigned DEN_W   = 2 * DIST_W + 1;
   localparam int unsigned QUO_W   = 17;
   localparam int unsigned STEP_W  = 5;

   localparam logic [SCALE_W-1:0] Q_SCALE_PER_M = 18'd256000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_DEPTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_HALF_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_DEPTH       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_HALF_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKER_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_END_LEVEL    = 3'd5;

   // Register reset values
   localparam logic [DIST_W-1:0]  RST_BLOCK_DEPTH      = 15'd500;
   localparam logic [DIST_W-1:0]  RST_BLOCK_HALF_WIDTH = 15'd250;
   localparam logic [DIST_W-1:0]  RST_ZONE_DEPTH       = 15'd2000;
   localparam logic [DIST_W-1:0]  RST_ZONE_HALF_WIDTH  = 15'd1500;
   localparam logic [COUNT_W-1:0] RST_BLOCKER_LIMIT    = 8'd3;
   localparam logic [Q88_W-1:0]   RST_ROW_END_LEVEL    = 16'd256;

   typedef struct packed {
      logic [DIST_W-1:0]  block_depth_mm;
      logic [DIST_W-1:0]  block_half_width_mm;
      logic [DIST_W-1:0]  zone_depth_mm;
      logic [DIST_W-1:0]  zone_half_width_mm;
      logic [COUNT_W-1:0] blocker_limit;
      logic [Q88_W-1:0]   row_end_level;
   } sops_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sops_div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_NUM_P,
      ST_DIV_P_GO,
      ST_DIV_P,
      ST_DIV_C_GO,
      ST_DIV_C,
      ST_UPDATE,
      ST_FINISH
   } sops_state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/sops_if.sv
// Scan obstacle push summary: valid/ready channel interfaces (points, results,
// register writes). Depends on sops_pkg for widths.
`default_nettype none

interface sops_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sops_pkg::COORD_W-1:0]    point_x_mm;
   logic signed [sops_pkg::COORD_W-1:0]    point_y_mm;
   logic                                   last_point;

   modport source (output valid, point_x_mm, point_y_mm, last_point, input ready);
   modport sink   (input valid, point_x_mm, point_y_mm, last_point, output ready);
endinterface

interface sops_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   blocked;
   logic                                   row_end;
   logic signed [sops_pkg::Q88_W-1:0]      steer_force;
   logic        [sops_pkg::Q88_W-1:0]      caution_level;

   modport source (output valid, blocked, row_end, steer_force, caution_level,
                   input ready);
   modport sink   (input valid, blocked, row_end, steer_force, caution_level,
                   output ready);
endinterface

interface sops_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [sops_pkg::CSR_IDX_W-1:0]         reg_index;
   logic [sops_pkg::CSR_DATA_W-1:0]        wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sops_csr_regs.sv
// Scan obstacle push summary: configuration register file behind the write channel.
// Depends on sops_pkg and sops_csr_if.
`default_nettype none

module sops_csr_regs (
   input  wire logic               clock,
   input  wire logic               reset,
   sops_csr_if.sink                csr_chan,
   output sops_pkg::sops_cfg_type  cfg
);

   sops_pkg::sops_cfg_type cfg_ff;
   sops_pkg::sops_cfg_type cfg_in;
   logic                   wr_fire;

   // Writes are never stalled
   assign csr_chan.ready = 1'b1;
   assign wr_fire        = csr_chan.valid;

   // Decode the register index; drop writes to unused indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (csr_chan.reg_index)
            sops_pkg::CSR_BLOCK_DEPTH:
               cfg_in.block_depth_mm = csr_chan.wr_data[sops_pkg::DIST_W-1:0];
            sops_pkg::CSR_BLOCK_HALF_WIDTH:
               cfg_in.block_half_width_mm = csr_chan.wr_data[sops_pkg::DIST_W-1:0];
            sops_pkg::CSR_ZONE_DEPTH:
               cfg_in.zone_depth_mm = csr_chan.wr_data[sops_pkg::DIST_W-1:0];
            sops_pkg::CSR_ZONE_HALF_WIDTH:
               cfg_in.zone_half_width_mm = csr_chan.wr_data[sops_pkg::DIST_W-1:0];
            sops_pkg::CSR_BLOCKER_LIMIT:
               cfg_in.blocker_limit = csr_chan.wr_data[sops_pkg::COUNT_W-1:0];
            sops_pkg::CSR_ROW_END_LEVEL:
               cfg_in.row_end_level = csr_chan.wr_data[sops_pkg::Q88_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_depth_mm      <= sops_pkg::RST_BLOCK_DEPTH;
         cfg_ff.block_half_width_mm <= sops_pkg::RST_BLOCK_HALF_WIDTH;
         cfg_ff.zone_depth_mm       <= sops_pkg::RST_ZONE_DEPTH;
         cfg_ff.zone_half_width_mm  <= sops_pkg::RST_ZONE_HALF_WIDTH;
         cfg_ff.blocker_limit       <= sops_pkg::RST_BLOCKER_LIMIT;
         cfg_ff.row_end_level       <= sops_pkg::RST_ROW_END_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sops_divider.sv
// Scan obstacle push summary: shared restoring divider, one quotient bit a cycle,
// with an overflow flag for quotients past 17 bits. Depends on sops_pkg.
`default_nettype none

module sops_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [sops_pkg::NUM_W-1:0]    numer,
   input  wire logic [sops_pkg::DEN_W-1:0]    denom,
   output logic      [sops_pkg::QUO_W-1:0]    quo,
   output logic                               ovf,
   output sops_pkg::sops_div_stat_type        stat
);

   localparam int unsigned HI_W = sops_pkg::NUM_W - sops_pkg::QUO_W;
   localparam logic [sops_pkg::STEP_W-1:0] LAST_STEP = 5'(sops_pkg::QUO_W - 1);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sops_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [sops_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [sops_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [sops_pkg::QUO_W-1:0]     low_ff, low_in;
   logic [sops_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic                           ovf_ff, ovf_in;
   logic [sops_pkg::DEN_W:0]       trial;
   logic                           fits;

   // Bring down the next numerator bit and compare against the divisor
   assign trial = {rem_ff, low_ff[sops_pkg::QUO_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         // Upper numerator bits already at or past the divisor: quotient overflows
         busy_in = 1'b1;
         step_in = '0;
         den_in  = denom;
         rem_in  = sops_pkg::DEN_W'(numer[sops_pkg::NUM_W-1:sops_pkg::QUO_W]);
         low_in  = numer[sops_pkg::QUO_W-1:0];
         quo_in  = '0;
         ovf_in  = {{(sops_pkg::DEN_W - HI_W){1'b0}},
                    numer[sops_pkg::NUM_W-1:sops_pkg::QUO_W]} >= denom;
      end else if (busy_ff) begin
         rem_in  = fits ? sops_pkg::DEN_W'(trial - {1'b0, den_ff})
                        : trial[sops_pkg::DEN_W-1:0];
         low_in  = {low_ff[sops_pkg::QUO_W-2:0], 1'b0};
         quo_in  = {quo_ff[sops_pkg::QUO_W-2:0], fits};
         step_in = step_ff + 5'd1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath holds its value once the division ends
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign quo       = quo_ff;
   assign ovf       = ovf_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/scan_obstacle_push_summary_unit.sv
// Scan obstacle push summary: top level with sequencer, shared multiplier and
// scan accumulators. Depends on sops_pkg, sops_if, sops_csr_regs, sops_divider.
//
//   channel   | dir  | transfer carries
//   ----------+------+--------------------------------------------------------
//   csr_chan  | in   | reg_index, wr_data (always ready)
//   req_chan  | in   | point_x_mm, point_y_mm, last_point
//   rsp_chan  | out  | blocked, row_end, steer_force, caution_level
//
// A point outside the push zone, or on a stopped scan, is done in the idle state.
// A point inside the zone also takes three multiplier passes for x^2 + y^2 and
// the push numerator, then two runs of the shared divider (push, then caution),
// each a start step, 17 quotient steps and a done step, and an update step. A last
// point adds a finish step to load the result register; that step stalls while an
// earlier result is still untaken, and points are taken behind a waiting result.
// Reset is synchronous and clears control, configuration and scan state only.
`default_nettype none

module scan_obstacle_push_summary_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   sops_csr_if.sink   csr_chan,
   sops_req_if.sink   req_chan,
   sops_rsp_if.source rsp_chan
);

   localparam int unsigned DW = sops_pkg::DIST_W;
   localparam int unsigned CW = sops_pkg::COORD_W;
   localparam int unsigned QW = sops_pkg::Q88_W;
   localparam int unsigned MW = sops_pkg::NUM_W;

   sops_pkg::sops_cfg_type       cfg;
   sops_pkg::sops_div_stat_type  div_stat;
   sops_pkg::sops_state_type     state_ff, state_in;

   // Control from the sequencer
   logic req_ready, rsp_valid;
   logic mul_sq_x, mul_sq_y, mul_num_y;
   logic d2_set, d2_add, div_start, push_cap, do_update, do_finish;

   // Point decode
   logic [CW-1:0]            pt_x, pt_y, y_mag;
   logic                     x_pos, in_block, in_zone, block_hit, block_stop, zone_go;
   logic                     req_fire, rsp_fire;
   logic [sops_pkg::COUNT_W-1:0] cnt_inc;

   // Point registers
   logic [DW-1:0] ax_ff, ay_ff;
   logic          y_pos_ff, last_ff;

   // Arithmetic datapath
   logic [DW-1:0]                 mul_a;
   logic [sops_pkg::SCALE_W-1:0]  mul_b;
   logic [MW-1:0]                 prod_ff, prod_in;
   logic [sops_pkg::DEN_W-1:0]    d2_ff, d2_in;
   logic [sops_pkg::QUO_W-1:0]    div_quo, pq_ff;
   logic                          div_ovf, povf_ff;

   // Scan accumulators
   logic [sops_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                          stopped_ff, stopped_in;
   logic signed [QW-1:0]          lowest_ff, lowest_in, highest_ff, highest_in;
   logic [QW-1:0]                 caution_ff, caution_in;
   logic signed [QW-1:0]          push;
   logic [QW-1:0]                 caution_sat;
   logic signed [QW:0]            force_sum;
   logic signed [QW-1:0]          force_sat;

   // Result register
   logic                 blocked_ff, eor_ff;
   logic signed [QW-1:0] force_ff;
   logic [QW-1:0]        caut_ff;
   logic                 rsp_pend_ff, rsp_pend_in;

   sops_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   sops_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (prod_ff),
      .denom (d2_ff),
      .quo   (div_quo),
      .ovf   (div_ovf),
      .stat  (div_stat)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign req_fire       = req_chan.valid && req_ready;
   assign rsp_fire       = rsp_valid && rsp_chan.ready;

   // Classify the offered point against the blocking box and the push zone
   always_comb begin
      pt_x       = req_chan.point_x_mm;
      pt_y       = req_chan.point_y_mm;
      y_mag      = pt_y[CW-1] ? (~pt_y + 16'd1) : pt_y;
      x_pos      = !pt_x[CW-1] && (pt_x != '0);
      in_block   = x_pos && (pt_x[DW-1:0] < cfg.block_depth_mm)
                   && (y_mag < {1'b0, cfg.block_half_width_mm});
      in_zone    = x_pos && (pt_x[DW-1:0] < cfg.zone_depth_mm)
                   && (y_mag < {1'b0, cfg.zone_half_width_mm});
      cnt_inc    = (count_ff == '1) ? count_ff : count_ff + 8'd1;
      block_hit  = !stopped_ff && in_block;
      block_stop = block_hit && (cnt_inc > cfg.blocker_limit);
      zone_go    = !stopped_ff && in_zone && !block_stop;
   end

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sops_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (zone_go)                    state_in = sops_pkg::ST_SQ_X;
               else if (req_chan.last_point)   state_in = sops_pkg::ST_FINISH;
            end
         end
         sops_pkg::ST_SQ_X:     state_in = sops_pkg::ST_SQ_Y;
         sops_pkg::ST_SQ_Y:     state_in = sops_pkg::ST_NUM_P;
         sops_pkg::ST_NUM_P:    state_in = sops_pkg::ST_DIV_P_GO;
         sops_pkg::ST_DIV_P_GO: state_in = sops_pkg::ST_DIV_P;
         sops_pkg::ST_DIV_P: begin
            if (div_stat.done) state_in = sops_pkg::ST_DIV_C_GO;
         end
         sops_pkg::ST_DIV_C_GO: state_in = sops_pkg::ST_DIV_C;
         sops_pkg::ST_DIV_C: begin
            if (div_stat.done) state_in = sops_pkg::ST_UPDATE;
         end
         sops_pkg::ST_UPDATE:
            state_in = last_ff ? sops_pkg::ST_FINISH : sops_pkg::ST_IDLE;
         sops_pkg::ST_FINISH: begin
            if (!rsp_pend_ff || rsp_chan.ready) state_in = sops_pkg::ST_IDLE;
         end
         default:               state_in = sops_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: control outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = rsp_pend_ff;
      mul_sq_x  = 1'b0;
      mul_sq_y  = 1'b0;
      mul_num_y = 1'b0;
      d2_set    = 1'b0;
      d2_add    = 1'b0;
      div_start = 1'b0;
      push_cap  = 1'b0;
      do_update = 1'b0;
      do_finish = 1'b0;
      unique case (state_ff)
         sops_pkg::ST_IDLE:     req_ready = 1'b1;
         sops_pkg::ST_SQ_X:     mul_sq_x  = 1'b1;
         sops_pkg::ST_SQ_Y: begin
            mul_sq_y = 1'b1;
            d2_set   = 1'b1;
         end
         sops_pkg::ST_NUM_P: begin
            mul_num_y = 1'b1;
            d2_add    = 1'b1;
         end
         sops_pkg::ST_DIV_P_GO: div_start = 1'b1;
         sops_pkg::ST_DIV_P:    push_cap  = div_stat.done;
         sops_pkg::ST_DIV_C_GO: div_start = 1'b1;
         sops_pkg::ST_DIV_C:    ;
         sops_pkg::ST_UPDATE:   do_update = 1'b1;
         sops_pkg::ST_FINISH:   do_finish = !rsp_pend_ff || rsp_chan.ready;
         default:               ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sops_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the point magnitudes for the arithmetic passes
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ax_ff    <= pt_x[DW-1:0];
         ay_ff    <= y_mag[DW-1:0];
         y_pos_ff <= !pt_y[CW-1] && (pt_y != '0);
         last_ff  <= req_chan.last_point;
      end
   end

   // Shared multiplier: x^2, y^2, then |y| and |x| times the Q8.8 scale
   always_comb begin
      mul_a = ax_ff;
      mul_b = sops_pkg::Q_SCALE_PER_M;
      if (mul_sq_x) begin
         mul_b = sops_pkg::SCALE_W'(ax_ff);
      end else if (mul_sq_y) begin
         mul_a = ay_ff;
         mul_b = sops_pkg::SCALE_W'(ay_ff);
      end else if (mul_num_y) begin
         mul_a = ay_ff;
      end
      prod_in = MW'(mul_a) * MW'(mul_b);
   end

   // Squared distance accumulates over two passes
   always_comb begin
      d2_in = d2_ff;
      if (d2_set)      d2_in = prod_ff[sops_pkg::DEN_W-1:0];
      else if (d2_add) d2_in = d2_ff + prod_ff[sops_pkg::DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      d2_ff   <= d2_in;
      if (push_cap) begin
         pq_ff   <= div_quo;
         povf_ff <= div_ovf;
      end
   end

   // Saturate the push (negated for points to the left) and the caution
   always_comb begin
      if (y_pos_ff) begin
         push = (povf_ff || (pq_ff > 17'd32768)) ? 16'sh8000
                                                 : QW'(16'd0 - pq_ff[QW-1:0]);
      end else begin
         push = (povf_ff || (pq_ff > 17'd32767)) ? 16'sh7FFF : QW'(pq_ff[QW-1:0]);
      end
      caution_sat = (div_ovf || div_quo[sops_pkg::QUO_W-1]) ? '1 : div_quo[QW-1:0];
      force_sum   = {lowest_ff[QW-1], lowest_ff} + {highest_ff[QW-1], highest_ff};
      if (force_sum[QW] != force_sum[QW-1]) begin
         force_sat = force_sum[QW] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         force_sat = force_sum[QW-1:0];
      end
   end

   // Advance the scan accumulators; clear them once the result is formed
   always_comb begin
      count_in   = count_ff;
      stopped_in = stopped_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      caution_in = caution_ff;
      if (req_fire && block_hit) begin
         count_in = cnt_inc;
         if (block_stop) stopped_in = 1'b1;
      end
      if (do_update) begin
         if (push < lowest_ff)         lowest_in  = push;
         if (push > highest_ff)        highest_in = push;
         if (caution_sat > caution_ff) caution_in = caution_sat;
      end
      if (do_finish) begin
         count_in   = '0;
         stopped_in = 1'b0;
         lowest_in  = '0;
         highest_in = '0;
         caution_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         stopped_ff <= 1'b0;
         lowest_ff  <= '0;
         highest_ff <= '0;
         caution_ff <= '0;
      end else begin
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
         caution_ff <= caution_in;
      end
   end

   // Result register, loaded once per scan and held until the transfer
   always_ff @(posedge clock) begin
      if (do_finish) begin
         blocked_ff <= stopped_ff;
         eor_ff     <= caution_ff < cfg.row_end_level;
         force_ff   <= force_sat;
         caut_ff    <= caution_ff;
      end
   end

   // Mark the result register full from load until its transfer
   always_comb begin
      rsp_pend_in = rsp_pend_ff;
      if (do_finish)     rsp_pend_in = 1'b1;
      else if (rsp_fire) rsp_pend_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_pend_ff <= 1'b0;
      end else begin
         rsp_pend_ff <= rsp_pend_in;
      end
   end

   assign rsp_chan.blocked       = blocked_ff;
   assign rsp_chan.row_end       = eor_ff;
   assign rsp_chan.steer_force   = force_ff;
   assign rsp_chan.caution_level = caut_ff;

   // The divider is only started when idle
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // Lowest push never rises above zero, highest never drops below
   a_push_signs: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (!highest_ff[QW-1] && (lowest_ff[QW-1] || (lowest_ff == '0))))
      else $error("push extremes have the wrong sign");

   // Forming a result leaves a clean scan behind
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      do_finish |=>
         ((count_ff == '0) && !stopped_ff && (caution_ff == '0)))
      else $error("scan state not cleared after result");

   // The caution result is only consumed after both divisions end
   a_update_after_div: assert property (@(posedge clock) disable iff (reset)
      do_update |-> (!div_stat.busy && $past(div_stat.done)))
      else $error("update before caution division finished");

   // A waiting result stays put until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(force_ff) && $stable(caut_ff)))
      else $error("result changed while waiting");

endmodule

`default_nettype wire

FILE: verif/scan_obstacle_push_summary_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for scan_obstacle_push_summary_unit: drives scans of points,
// predicts each scan summary and compares it with every result transfer.
// Depends on sops_pkg, the sops_if channel interfaces and the unit's RTL.

module scan_obstacle_push_summary_unit_tb;

   typedef struct {
      logic signed [sops_pkg::COORD_W-1:0] x;
      logic signed [sops_pkg::COORD_W-1:0] y;
      logic                                last;
   } point_type;

   typedef struct {
      logic                              blocked;
      logic                              row_end;
      logic signed [sops_pkg::Q88_W-1:0] steer_force;
      logic [sops_pkg::Q88_W-1:0]        caution_level;
   } summary_type;

   logic clock;
   logic reset;

   sops_req_if req_chan ();
   sops_rsp_if rsp_chan ();
   sops_csr_if csr_chan ();

   scan_obstacle_push_summary_unit uut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   point_type              pending_points[$];
   summary_type            summary_q[$];
   point_type              next_point;
   sops_pkg::sops_cfg_type cfg;

   // Running scan state of the prediction
   logic [sops_pkg::COUNT_W-1:0] blocker_count;
   bit                           scan_stopped;
   int                           push_lo;
   int                           push_hi;
   int                           caution_max;

   int error_count = 0;
   bit idling_on;
   bit hold_request;
   bit hold_used;
   int send_gap;
   int recv_stall;
   int hold_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic clear_scan_state();
      blocker_count = '0;
      scan_stopped  = 1'b0;
      push_lo       = 0;
      push_hi       = 0;
      caution_max   = 0;
   endtask

   // Fold one accepted point into the scan state; queue the summary on the last point
   task automatic fold_point(input point_type p);
      int          x, y, ax, ay, push, steer_sum;
      longint      d2, pm, cm;
      summary_type s;
      x  = int'(p.x);
      y  = int'(p.y);
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (!scan_stopped) begin
         if (x > 0 && x < int'(cfg.block_depth_mm) && ay < int'(cfg.block_half_width_mm)) begin
            if (blocker_count != 8'd255)
               blocker_count++;
            if (blocker_count > cfg.blocker_limit)
               scan_stopped = 1'b1;
         end
         if (!scan_stopped && x > 0 && x < int'(cfg.zone_depth_mm)
             && ay < int'(cfg.zone_half_width_mm)) begin
            d2 = longint'(ax) * ax + longint'(ay) * ay;
            pm = (longint'(ay) * longint'(sops_pkg::Q_SCALE_PER_M)) / d2;
            cm = (longint'(ax) * longint'(sops_pkg::Q_SCALE_PER_M)) / d2;
            if (y > 0)
               push = (pm > 32768) ? -32768 : -int'(pm);
            else
               push = (pm > 32767) ? 32767 : int'(pm);
            if (push < push_lo)
               push_lo = push;
            if (push > push_hi)
               push_hi = push;
            if (cm > 65535)
               cm = 65535;
            if (int'(cm) > caution_max)
               caution_max = int'(cm);
         end
      end
      if (p.last) begin
         steer_sum = push_lo + push_hi;
         if (steer_sum > 32767)
            steer_sum = 32767;
         if (steer_sum < -32768)
            steer_sum = -32768;
         s.blocked       = scan_stopped;
         s.row_end       = caution_max < int'(cfg.row_end_level);
         s.steer_force   = steer_sum[sops_pkg::Q88_W-1:0];
         s.caution_level = caution_max[sops_pkg::Q88_W-1:0];
         summary_q.push_back(s);
         clear_scan_state();
      end
   endtask

   // Compare one result transfer with the oldest queued summary
   task automatic check_summary();
      summary_type s;
      if (summary_q.size() == 0) begin
         report_mismatch("result with nothing expected, caution_level",
                         longint'(rsp_chan.caution_level), -1);
         return;
      end
      s = summary_q.pop_front();
      if (rsp_chan.blocked !== s.blocked)
         report_mismatch("blocked", longint'(rsp_chan.blocked), longint'(s.blocked));
      if (rsp_chan.row_end !== s.row_end)
         report_mismatch("row_end", longint'(rsp_chan.row_end), longint'(s.row_end));
      if (rsp_chan.steer_force !== s.steer_force)
         report_mismatch("steer_force", longint'(rsp_chan.steer_force),
                         longint'(s.steer_force));
      if (rsp_chan.caution_level !== s.caution_level)
         report_mismatch("caution_level", longint'(rsp_chan.caution_level),
                         longint'(s.caution_level));
   endtask

   // Mirror register writes at each configuration transfer
   always @(posedge clock) begin
      if (reset) begin
         cfg <= '{sops_pkg::RST_BLOCK_DEPTH, sops_pkg::RST_BLOCK_HALF_WIDTH,
                  sops_pkg::RST_ZONE_DEPTH, sops_pkg::RST_ZONE_HALF_WIDTH,
                  sops_pkg::RST_BLOCKER_LIMIT, sops_pkg::RST_ROW_END_LEVEL};
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.reg_index)
            sops_pkg::CSR_BLOCK_DEPTH:
               cfg.block_depth_mm      <= csr_chan.wr_data[sops_pkg::DIST_W-1:0];
            sops_pkg::CSR_BLOCK_HALF_WIDTH:
               cfg.block_half_width_mm <= csr_chan.wr_data[sops_pkg::DIST_W-1:0];
            sops_pkg::CSR_ZONE_DEPTH:
               cfg.zone_depth_mm       <= csr_chan.wr_data[sops_pkg::DIST_W-1:0];
            sops_pkg::CSR_ZONE_HALF_WIDTH:
               cfg.zone_half_width_mm  <= csr_chan.wr_data[sops_pkg::DIST_W-1:0];
            sops_pkg::CSR_BLOCKER_LIMIT:
               cfg.blocker_limit       <= csr_chan.wr_data[sops_pkg::COUNT_W-1:0];
            sops_pkg::CSR_ROW_END_LEVEL:
               cfg.row_end_level       <= csr_chan.wr_data[sops_pkg::Q88_W-1:0];
            default: ;
         endcase
      end
   end

   // Point driver: predict on each transfer, then offer the next point or idle
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
         clear_scan_state();
      end else begin
         if (req_chan.valid && req_chan.ready)
            fold_point(point_type'{req_chan.point_x_mm, req_chan.point_y_mm,
                                   req_chan.last_point});
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
               send_gap       <= $urandom_range(0, 8);
               req_chan.valid <= 1'b0;
            end else if (pending_points.size() != 0) begin
               next_point          = pending_points.pop_front();
               req_chan.point_x_mm <= next_point.x;
               req_chan.point_y_mm <= next_point.y;
               req_chan.last_point <= next_point.last;
               req_chan.valid      <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each transfer, then stall, hold off or accept
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall     <= 0;
         hold_left      <= 0;
         hold_used      <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_summary();
         if (hold_left > 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (hold_request && !hold_used && rsp_chan.valid) begin
            // long hold-off so the unit backs up and stalls its point input
            hold_left      <= 399;
            hold_used      <= 1'b1;
            rsp_chan.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall     <= recv_stall - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            recv_stall     <= $urandom_range(0, 8);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [sops_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sops_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wr_data   <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic random_config();
      logic [sops_pkg::CSR_DATA_W-1:0] bd, bh;
      bd = 16'($urandom_range(50, 1500));
      bh = 16'($urandom_range(20, 800));
      write_reg(sops_pkg::CSR_BLOCK_DEPTH, bd);
      write_reg(sops_pkg::CSR_BLOCK_HALF_WIDTH, bh);
      write_reg(sops_pkg::CSR_ZONE_DEPTH, 16'($urandom_range(bd, 6000)));
      write_reg(sops_pkg::CSR_ZONE_HALF_WIDTH, 16'($urandom_range(bh, 4000)));
      write_reg(sops_pkg::CSR_BLOCKER_LIMIT, 16'($urandom_range(0, 6)));
      write_reg(sops_pkg::CSR_ROW_END_LEVEL, 16'($urandom_range(0, 65535)));
   endtask

   // Wait until every point is taken and every summary has come back, then settle
   task automatic drain();
      do @(negedge clock);
      while (pending_points.size() != 0 || req_chan.valid || summary_q.size() != 0);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic signed [sops_pkg::COORD_W-1:0] pick_coord(input int lim,
                                                                      input bit fwd);
      int v;
      if (fwd)
         v = int'($urandom_range(0, lim + 1)) - 1;
      else
         v = int'($urandom_range(0, 2 * lim + 2)) - (lim + 1);
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[sops_pkg::COORD_W-1:0];
   endfunction

   task automatic add_point(input int x, input int y, input bit last);
      point_type p;
      p.x    = x[sops_pkg::COORD_W-1:0];
      p.y    = y[sops_pkg::COORD_W-1:0];
      p.last = last;
      pending_points.push_back(p);
   endtask

   // Queue whole scans, mostly near the blocking box and push zone
   task automatic add_random_scans(input int n_points);
      int        total, len, k;
      point_type p;
      int        corners[5] = '{0, 1, -1, 32767, -32768};
      total = 0;
      while (total < n_points) begin
         len = $urandom_range(1, 10);
         for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  p.x = 16'($urandom);
                  p.y = 16'($urandom);
               end
               2, 3, 4: begin
                  p.x = pick_coord(int'(cfg.block_depth_mm), 1'b1);
                  p.y = pick_coord(int'(cfg.block_half_width_mm), 1'b0);
               end
               9: begin
                  p.x = 16'(corners[$urandom_range(0, 4)]);
                  p.y = 16'(corners[$urandom_range(0, 4)]);
               end
               default: begin
                  p.x = pick_coord(int'(cfg.zone_depth_mm), 1'b1);
                  p.y = pick_coord(int'(cfg.zone_half_width_mm), 1'b0);
               end
            endcase
            p.last = (k == len - 1);
            pending_points.push_back(p);
         end
         total += len;
      end
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.point_x_mm = '0;
      req_chan.point_y_mm = '0;
      req_chan.last_point = 1'b0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.reg_index  = '0;
      csr_chan.wr_data    = '0;
      idling_on           = 1'b1;
      hold_request        = 1'b0;
      reset               = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: blocking scan, stopped-scan points, then the last point
      add_point(100, 0, 0);
      add_point(200, 10, 0);
      add_point(300, -10, 0);
      add_point(400, 0, 0);
      add_point(1000, 500, 0);
      add_point(-32768, -32768, 1);
      // Coordinate extremes and saturating push and caution
      add_point(32767, 32767, 0);
      add_point(-32768, -32768, 0);
      add_point(0, 0, 0);
      add_point(1, 1, 0);
      add_point(1, -1, 0);
      add_point(1, 0, 0);
      add_point(32767, -32768, 0);
      add_point(1999, 1499, 1);
      // Nothing in the zone, so the caution stays low
      add_point(2000, 0, 0);
      add_point(100, 1500, 0);
      add_point(-5, 0, 1);
      // Lone last point, and a far point with a small caution
      add_point(1000, -800, 1);
      add_point(600, -1499, 0);
      add_point(1999, 0, 1);
      add_random_scans(60);
      drain();

      // Random settings, with a long result hold-off
      random_config();
      repeat (2) @(posedge clock);
      hold_request = 1'b1;
      add_random_scans(80);
      drain();

      // Zero-sized box and zone, zero limit and level
      write_reg(sops_pkg::CSR_BLOCK_DEPTH, 16'd0);
      write_reg(sops_pkg::CSR_BLOCK_HALF_WIDTH, 16'd0);
      write_reg(sops_pkg::CSR_ZONE_DEPTH, 16'd0);
      write_reg(sops_pkg::CSR_ZONE_HALF_WIDTH, 16'd0);
      write_reg(sops_pkg::CSR_BLOCKER_LIMIT, 16'd0);
      write_reg(sops_pkg::CSR_ROW_END_LEVEL, 16'd0);
      repeat (2) @(posedge clock);
      add_random_scans(40);
      drain();

      // Full-scale settings through wide values; unused indexes must be ignored
      write_reg(sops_pkg::CSR_BLOCK_DEPTH, 16'hFFFF);
      write_reg(sops_pkg::CSR_BLOCK_HALF_WIDTH, 16'hFFFF);
      write_reg(sops_pkg::CSR_ZONE_DEPTH, 16'hFFFF);
      write_reg(sops_pkg::CSR_ZONE_HALF_WIDTH, 16'hFFFF);
      write_reg(sops_pkg::CSR_BLOCKER_LIMIT, 16'hFFFF);
      write_reg(sops_pkg::CSR_ROW_END_LEVEL, 16'hFFFF);
      write_reg(sops_pkg::CSR_ROW_END_LEVEL + 3'd1, 16'($urandom));
      write_reg(sops_pkg::CSR_ROW_END_LEVEL + 3'd2, 16'($urandom));
      repeat (2) @(posedge clock);
      add_random_scans(80);
      drain();

      // First blocker stops the scan
      random_config();
      write_reg(sops_pkg::CSR_BLOCKER_LIMIT, 16'd0);
      repeat (2) @(posedge clock);
      add_random_scans(60);
      drain();

      // Closing stretch at full rate on both sides
      random_config();
      repeat (2) @(posedge clock);
      idling_on = 1'b0;
      add_random_scans(80);
      drain();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/sops_pkg.sv
hw/rtl/sops_if.sv
hw/rtl/sops_csr_regs.sv
hw/rtl/sops_divider.sv
hw/rtl/scan_obstacle_push_summary_unit.sv
verif/scan_obstacle_push_summary_unit_tb.sv
